>>> rtl/pkgls_pkg.sv
`timescale 1ns / 1ps
package pkgls_pkg;

    // field widths of the request and response channels
    localparam int ACTION_W = 2;
    localparam int PID_W    = 10;
    localparam int DOC_W    = 22;
    localparam int PROP_W   = 6;
    localparam int STATUS_W = 3;

    // default sizing
    localparam int DEF_PARENT_DEPTH = 1024;
    localparam int DEF_POOL_DEPTH   = 4096;
    localparam int DEF_MAX_CHILDREN = 64;

    // per-list counters hold up to 64 entries
    localparam int CNT_W = 7;

    localparam logic [DOC_W-1:0] BAD_CHILD = {DOC_W{1'b1}};

    // action codes on the request channel
    localparam logic [ACTION_W-1:0] ACT_APPEND  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_GET     = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_MIGRATE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd3;

    // response status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ID   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CORRUPT  = 3'd4;

    // classified command handed from front to back
    typedef enum logic [2:0] {
        CMD_APPEND,
        CMD_GET,
        CMD_MIGRATE,
        CMD_CLEAR,
        CMD_REJECT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t           op;
        logic [PID_W-1:0]  pid;
        logic [PID_W-1:0]  npid;
        logic [DOC_W-1:0]  doc;
        logic [PROP_W-1:0] prop;
    } cmd_t;

endpackage

>>> rtl/pkgls_req_if.sv
`timescale 1ns / 1ps
interface pkgls_req_if;
    logic                            valid;
    logic                            ready;
    logic [pkgls_pkg::ACTION_W-1:0]  action;
    logic [pkgls_pkg::PID_W-1:0]     parent_id;
    logic [pkgls_pkg::PID_W-1:0]     new_parent_id;
    logic [pkgls_pkg::DOC_W-1:0]     child_doc_id;
    logic [pkgls_pkg::PROP_W-1:0]    child_property_id;

    modport source (output valid, action, parent_id, new_parent_id, child_doc_id,
                    child_property_id, input ready);
    modport sink (input valid, action, parent_id, new_parent_id, child_doc_id,
                  child_property_id, output ready);
endinterface

>>> rtl/pkgls_rsp_if.sv
`timescale 1ns / 1ps
interface pkgls_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [pkgls_pkg::STATUS_W-1:0]  status;
    logic                            child_valid;
    logic [pkgls_pkg::DOC_W-1:0]     out_child_doc_id;
    logic [pkgls_pkg::PROP_W-1:0]    out_property_id;
    logic                            last;

    modport source (output valid, status, child_valid, out_child_doc_id, out_property_id,
                    last, input ready);
    modport sink (input valid, status, child_valid, out_child_doc_id, out_property_id,
                  last, output ready);
endinterface

>>> rtl/pkgls_front.sv
`timescale 1ns / 1ps
module pkgls_front #(
    parameter int PARENT_DEPTH = pkgls_pkg::DEF_PARENT_DEPTH
) (
    pkgls_req_if.sink         req,
    input  logic              q_full,
    output logic              q_push,
    output pkgls_pkg::cmd_t   q_data
);

    logic pid_bad;
    logic npid_bad;

    // parent id range checks
    assign pid_bad  = 32'(req.parent_id) >= 32'(PARENT_DEPTH);
    assign npid_bad = 32'(req.new_parent_id) >= 32'(PARENT_DEPTH);

    assign req.ready = !q_full;
    assign q_push    = req.valid && !q_full;

    // classify the request
    always_comb
    begin
        q_data.pid  = req.parent_id;
        q_data.npid = req.new_parent_id;
        q_data.doc  = req.child_doc_id;
        q_data.prop = req.child_property_id;
        unique case (req.action)
            pkgls_pkg::ACT_APPEND:
                q_data.op = (pid_bad || req.child_doc_id == pkgls_pkg::BAD_CHILD)
                            ? pkgls_pkg::CMD_REJECT : pkgls_pkg::CMD_APPEND;
            pkgls_pkg::ACT_GET:
                q_data.op = pid_bad ? pkgls_pkg::CMD_REJECT : pkgls_pkg::CMD_GET;
            pkgls_pkg::ACT_MIGRATE:
                q_data.op = (pid_bad || npid_bad) ? pkgls_pkg::CMD_REJECT
                                                  : pkgls_pkg::CMD_MIGRATE;
            default:
                q_data.op = pkgls_pkg::CMD_CLEAR;
        endcase
    end

endmodule

>>> rtl/pkgls_fifo.sv
`timescale 1ns / 1ps
module pkgls_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pkgls_pkg::cmd_t   push_data,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output pkgls_pkg::cmd_t   head
);

    pkgls_pkg::cmd_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign head  = slot_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

>>> rtl/pkgls_back.sv
`timescale 1ns / 1ps
module pkgls_back #(
    parameter int PARENT_DEPTH = pkgls_pkg::DEF_PARENT_DEPTH,
    parameter int POOL_DEPTH   = pkgls_pkg::DEF_POOL_DEPTH,
    parameter int MAX_CHILDREN = pkgls_pkg::DEF_MAX_CHILDREN
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  pkgls_pkg::cmd_t   q_head,
    output logic              q_pop,
    pkgls_rsp_if.source       rsp
);

    localparam int PW = $clog2(PARENT_DEPTH);
    localparam int AW = $clog2(POOL_DEPTH);
    localparam int TW = $clog2(POOL_DEPTH + 1);
    localparam int CW = pkgls_pkg::CNT_W;
    localparam int DW = pkgls_pkg::DOC_W + pkgls_pkg::PROP_W;

    typedef struct packed {
        logic          valid;
        logic [AW-1:0] base;
        logic [CW-1:0] cap;
        logic [CW-1:0] used;
    } ent_t;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_LOOK, S_COPY, S_APPW, S_MIG, S_GRD, S_GOUT, S_RSP
    } state_t;

    // parent table and child pool
    ent_t          ptab [PARENT_DEPTH];
    logic [DW-1:0] pool [POOL_DEPTH];
    ent_t          ptab_q;
    logic [DW-1:0] pool_q;

    logic          ptab_we;
    logic [PW-1:0] ptab_waddr;
    ent_t          ptab_wdata;
    logic [PW-1:0] ptab_raddr;
    logic          pool_we;
    logic [AW-1:0] pool_waddr;
    logic [DW-1:0] pool_wdata;
    logic [AW-1:0] pool_raddr;

    state_t                         state_reg;
    logic [PW-1:0]                  clr_cnt_reg;
    logic                           clr_rsp_reg;
    pkgls_pkg::cmd_t                cmd_reg;
    logic [TW-1:0]                  top_reg;
    logic [AW-1:0]                  wbase_reg;
    logic [AW-1:0]                  obase_reg;
    logic [CW-1:0]                  wcap_reg;
    logic [CW-1:0]                  wused_reg;
    logic [CW-1:0]                  cnt_reg;
    logic [pkgls_pkg::STATUS_W-1:0] status_reg;

    logic                           out_valid_reg;
    logic [pkgls_pkg::STATUS_W-1:0] out_status_reg;
    logic                           out_cv_reg;
    logic [pkgls_pkg::DOC_W-1:0]    out_doc_reg;
    logic [pkgls_pkg::PROP_W-1:0]   out_prop_reg;
    logic                           out_last_reg;
    logic                           out_free;
    logic                           out_load;

    logic [TW-1:0] e_end;
    logic [TW-1:0] room;
    logic [CW-1:0] ncap;

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_status_reg;
    assign rsp.child_valid      = out_cv_reg;
    assign rsp.out_child_doc_id = out_doc_reg;
    assign rsp.out_property_id  = out_prop_reg;
    assign rsp.last             = out_last_reg;
    assign out_free             = !out_valid_reg || rsp.ready;
    assign out_load             = ((state_reg == S_RSP) || (state_reg == S_GOUT)) && out_free;

    assign q_pop = (state_reg == S_IDLE) && !q_empty;

    // list geometry of the looked-up entry
    assign e_end = TW'(ptab_q.base) + TW'(ptab_q.cap);
    assign room  = TW'(POOL_DEPTH) - top_reg;
    assign ncap  = {ptab_q.cap[CW-2:0], 1'b0};

    // memory addressing
    assign ptab_raddr = PW'(q_head.pid);
    assign pool_raddr = (state_reg == S_COPY) ? obase_reg + AW'(cnt_reg)
                                              : wbase_reg + AW'(cnt_reg);

    always_comb
    begin
        ptab_we    = 1'b0;
        ptab_waddr = PW'(cmd_reg.pid);
        ptab_wdata = '0;
        pool_we    = 1'b0;
        pool_waddr = wbase_reg + AW'(wused_reg);
        pool_wdata = {cmd_reg.doc, cmd_reg.prop};
        unique case (state_reg)
            S_CLR:
            begin
                ptab_we    = 1'b1;
                ptab_waddr = clr_cnt_reg;
            end
            S_LOOK:
            begin
                if (cmd_reg.op == pkgls_pkg::CMD_MIGRATE && ptab_q.valid &&
                    cmd_reg.pid != cmd_reg.npid)
                begin
                    ptab_we    = 1'b1;
                    ptab_waddr = PW'(cmd_reg.npid);
                    ptab_wdata = ptab_q;
                end
            end
            S_MIG:
            begin
                ptab_we = 1'b1;
            end
            S_COPY:
            begin
                pool_we    = cnt_reg != '0;
                pool_waddr = wbase_reg + AW'(cnt_reg - CW'(1));
                pool_wdata = pool_q;
            end
            S_APPW:
            begin
                pool_we    = 1'b1;
                ptab_we    = 1'b1;
                ptab_wdata = '{valid: 1'b1, base: wbase_reg, cap: wcap_reg,
                               used: wused_reg + CW'(1)};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ptab_we)
        begin
            ptab[ptab_waddr] <= ptab_wdata;
        end
        ptab_q <= ptab[ptab_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pool_we)
        begin
            pool[pool_waddr] <= pool_wdata;
        end
        pool_q <= pool[pool_raddr];
    end

    // sequencer and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            clr_cnt_reg    <= '0;
            clr_rsp_reg    <= 1'b0;
            cmd_reg        <= '0;
            top_reg        <= '0;
            wbase_reg      <= '0;
            obase_reg      <= '0;
            wcap_reg       <= '0;
            wused_reg      <= '0;
            cnt_reg        <= '0;
            status_reg     <= pkgls_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
            out_status_reg <= pkgls_pkg::ST_OK;
            out_cv_reg     <= 1'b0;
            out_doc_reg    <= '0;
            out_prop_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLR:
                begin
                    top_reg <= '0;
                    if (clr_cnt_reg == PW'(PARENT_DEPTH - 1))
                    begin
                        clr_cnt_reg <= '0;
                        clr_rsp_reg <= 1'b0;
                        status_reg  <= pkgls_pkg::ST_OK;
                        state_reg   <= clr_rsp_reg ? S_RSP : S_IDLE;
                    end
                    else
                    begin
                        clr_cnt_reg <= clr_cnt_reg + PW'(1);
                    end
                end
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cmd_reg <= q_head;
                        cnt_reg <= '0;
                        priority case (q_head.op)
                            pkgls_pkg::CMD_REJECT:
                            begin
                                status_reg <= pkgls_pkg::ST_BAD_ID;
                                state_reg  <= S_RSP;
                            end
                            pkgls_pkg::CMD_CLEAR:
                            begin
                                clr_rsp_reg <= 1'b1;
                                state_reg   <= S_CLR;
                            end
                            default:
                            begin
                                state_reg <= S_LOOK;
                            end
                        endcase
                    end
                end
                S_LOOK:
                begin
                    priority case (cmd_reg.op)
                        pkgls_pkg::CMD_APPEND:
                        begin
                            if (!ptab_q.valid)
                            begin
                                // first child: capacity one at the pool top
                                if (top_reg >= TW'(POOL_DEPTH))
                                begin
                                    status_reg <= pkgls_pkg::ST_FULL;
                                    state_reg  <= S_RSP;
                                end
                                else
                                begin
                                    wbase_reg  <= AW'(top_reg);
                                    wcap_reg   <= CW'(1);
                                    wused_reg  <= '0;
                                    top_reg    <= top_reg + TW'(1);
                                    status_reg <= pkgls_pkg::ST_OK;
                                    state_reg  <= S_APPW;
                                end
                            end
                            else if (ptab_q.used < ptab_q.cap)
                            begin
                                wbase_reg  <= ptab_q.base;
                                wcap_reg   <= ptab_q.cap;
                                wused_reg  <= ptab_q.used;
                                status_reg <= pkgls_pkg::ST_OK;
                                state_reg  <= S_APPW;
                            end
                            else if (ptab_q.used >= CW'(MAX_CHILDREN))
                            begin
                                status_reg <= pkgls_pkg::ST_TOO_MANY;
                                state_reg  <= S_RSP;
                            end
                            else if (e_end == top_reg)
                            begin
                                // grow in place
                                if (TW'(ptab_q.cap) > room)
                                begin
                                    status_reg <= pkgls_pkg::ST_FULL;
                                    state_reg  <= S_RSP;
                                end
                                else
                                begin
                                    wbase_reg  <= ptab_q.base;
                                    wused_reg  <= ptab_q.used;
                                    top_reg    <= top_reg + TW'(ptab_q.cap);
                                    wcap_reg   <= ncap;
                                    status_reg <= pkgls_pkg::ST_OK;
                                    state_reg  <= S_APPW;
                                end
                            end
                            else if (TW'(ncap) > room)
                            begin
                                status_reg <= pkgls_pkg::ST_FULL;
                                state_reg  <= S_RSP;
                            end
                            else
                            begin
                                // relocate to the pool top
                                wbase_reg  <= AW'(top_reg);
                                obase_reg  <= ptab_q.base;
                                wcap_reg   <= ncap;
                                wused_reg  <= ptab_q.used;
                                top_reg    <= top_reg + TW'(ncap);
                                status_reg <= pkgls_pkg::ST_OK;
                                state_reg  <= S_COPY;
                            end
                        end
                        pkgls_pkg::CMD_GET:
                        begin
                            wbase_reg  <= ptab_q.base;
                            wused_reg  <= ptab_q.used;
                            status_reg <= pkgls_pkg::ST_OK;
                            state_reg  <= (ptab_q.valid && ptab_q.used != '0) ? S_GRD : S_RSP;
                        end
                        default:
                        begin
                            status_reg <= pkgls_pkg::ST_OK;
                            state_reg  <= (ptab_q.valid && cmd_reg.pid != cmd_reg.npid)
                                          ? S_MIG : S_RSP;
                        end
                    endcase
                end
                S_COPY:
                begin
                    if (cnt_reg == wused_reg)
                    begin
                        state_reg <= S_APPW;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                S_APPW:
                begin
                    status_reg <= pkgls_pkg::ST_OK;
                    state_reg  <= S_RSP;
                end
                S_MIG:
                begin
                    state_reg <= S_RSP;
                end
                S_GRD:
                begin
                    state_reg <= S_GOUT;
                end
                S_GOUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= pkgls_pkg::ST_OK;
                        out_cv_reg     <= 1'b1;
                        out_doc_reg    <= pool_q[DW-1:pkgls_pkg::PROP_W];
                        out_prop_reg   <= pool_q[pkgls_pkg::PROP_W-1:0];
                        out_last_reg   <= (cnt_reg + CW'(1)) == wused_reg;
                        cnt_reg        <= cnt_reg + CW'(1);
                        state_reg      <= ((cnt_reg + CW'(1)) == wused_reg) ? S_IDLE
                                                                            : S_GRD;
                    end
                end
                S_RSP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        out_cv_reg     <= 1'b0;
                        out_doc_reg    <= '0;
                        out_prop_reg   <= '0;
                        out_last_reg   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/per_key_growable_list_store.sv
`timescale 1ns / 1ps
// Per-parent child lists in a bump-allocated pool. Requests enter a two-deep
// queue and are carried out one at a time by a sequencer over the parent
// table and pool memories. Append looks up the parent entry and writes the
// child and the updated entry, first copying the used entries to the pool
// top when the list is relocated; a rejected id, migrate and the error
// cases give a single response; get reads the children out one at a time;
// clear and reset walk the parent table, one entry a cycle, before the next
// request is carried out. The response register and the queue let up to
// three requests be taken while a response waits.
module per_key_growable_list_store #(
    parameter int PARENT_DEPTH = pkgls_pkg::DEF_PARENT_DEPTH,
    parameter int POOL_DEPTH   = pkgls_pkg::DEF_POOL_DEPTH,
    parameter int MAX_CHILDREN = pkgls_pkg::DEF_MAX_CHILDREN
) (
    input  logic        clk,
    input  logic        rst_n,
    pkgls_req_if.sink   req,
    pkgls_rsp_if.source rsp
);

    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    pkgls_pkg::cmd_t q_data;
    pkgls_pkg::cmd_t q_head;

    // request classification
    pkgls_front #(
        .PARENT_DEPTH (PARENT_DEPTH)
    ) u_front (
        .req    (req),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_data)
    );

    // decoupling queue
    pkgls_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    // list store engine
    pkgls_back #(
        .PARENT_DEPTH (PARENT_DEPTH),
        .POOL_DEPTH   (POOL_DEPTH),
        .MAX_CHILDREN (MAX_CHILDREN)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule

>>> rtl/pkgls_checker.sv
`timescale 1ns / 1ps
module pkgls_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [pkgls_pkg::STATUS_W-1:0] rsp_status,
    input logic                           rsp_child_valid,
    input logic [pkgls_pkg::DOC_W-1:0]    rsp_doc,
    input logic [pkgls_pkg::PROP_W-1:0]   rsp_prop,
    input logic                           rsp_last
);

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
        $stable(rsp_doc) && $stable(rsp_prop) && $stable(rsp_last))
        else $error("response changed while stalled");

    // a response without a child ends its request
    a_plain_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_child_valid |-> rsp_last)
        else $error("non-child response not last");

    // children only come with ok status
    a_child_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_child_valid |-> rsp_status == pkgls_pkg::ST_OK)
        else $error("child with error status");

    // empty payload when no child is carried
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_child_valid |-> rsp_doc == '0 && rsp_prop == '0)
        else $error("payload set without child");

endmodule

bind per_key_growable_list_store pkgls_checker u_pkgls_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_child_valid (rsp.child_valid),
    .rsp_doc         (rsp.out_child_doc_id),
    .rsp_prop        (rsp.out_property_id),
    .rsp_last        (rsp.last)
);
